>>> design/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg: rangefinder frame parser package
// Shared constants, register indexes and the types passed between modules.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST     = 2'd2;

  localparam logic [7:0]  HEADER_RST   = 8'h5C;
  localparam logic [15:0] MIN_DIST_RST = 16'd50;
  localparam logic [15:0] MAX_DIST_RST = 16'd50000;

  localparam logic [7:0] BYTE_5A = 8'h5A;
  localparam logic [7:0] BYTE_55 = 8'h55;

  typedef struct packed {
    logic [7:0]  hdr_byte;
    logic [15:0] min_mm;
    logic [15:0] max_mm;
  } cfg_t;

  typedef struct packed {
    logic        frame_done;
    logic [15:0] range_mm;
    logic        in_range;
    logic        checksum_error;
    logic [31:0] sample_total;
    logic [31:0] error_total;
    logic [31:0] byte_total;
    logic [31:0] count_5a_bytes;
    logic [31:0] count_header_bytes;
    logic [31:0] count_55_bytes;
  } result_t;

endpackage

>>> design/rfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// rfp_cfg_regs: configuration registers
// Header byte and distance window, written through a plain write port.
// ----------------------------------------------------------------------------
module rfp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rfp_pkg::cfg_t                 cfg
);
  import rfp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_HEADER: cfg_nxt.hdr_byte = cfg_wdata[7:0];
        REG_MIN_DIST:     cfg_nxt.min_mm   = cfg_wdata[15:0];
        REG_MAX_DIST:     cfg_nxt.max_mm   = cfg_wdata[15:0];
        default:          cfg_nxt = cfg_r;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_byte <= HEADER_RST;
      cfg_r.min_mm   <= MIN_DIST_RST;
      cfg_r.max_mm   <= MAX_DIST_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/rfp_parser.sv
// ----------------------------------------------------------------------------
// rfp_parser: frame state machine and counters
// Computes the result for the byte in the input stage and commits the
// parser state when that byte moves on to the result register.
// ----------------------------------------------------------------------------
module rfp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  rfp_pkg::cfg_t    cfg,
  output rfp_pkg::result_t res
);
  import rfp_pkg::*;

  typedef enum logic [1:0] {PH_WAIT, PH_LOW, PH_HIGH, PH_CHECK} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [31:0] good_r, bad_r, bytes_r, c5a_r, chdr_r, c55_r;

  logic        is_hdr;
  logic [7:0]  expect_sum;
  logic [15:0] mm_val;

  assign is_hdr     = (rx_byte == cfg.hdr_byte);
  assign expect_sum = ~(low_r + high_r);
  assign mm_val     = {high_r, low_r};

  always_comb begin
    phase_nxt = phase_r;
    low_nxt   = low_r;
    high_nxt  = high_r;

    res.frame_done         = 1'b0;
    res.range_mm           = '0;
    res.in_range           = 1'b0;
    res.checksum_error     = 1'b0;
    res.sample_total       = good_r;
    res.error_total        = bad_r;
    res.byte_total         = bytes_r + 32'd1;
    res.count_5a_bytes     = c5a_r;
    res.count_header_bytes = chdr_r;
    res.count_55_bytes     = c55_r;

    // 0x5A wins over the header, the header over 0x55
    if (rx_byte == BYTE_5A) begin
      res.count_5a_bytes = c5a_r + 32'd1;
    end else if (is_hdr) begin
      res.count_header_bytes = chdr_r + 32'd1;
    end else if (rx_byte == BYTE_55) begin
      res.count_55_bytes = c55_r + 32'd1;
    end

    unique case (phase_r)
      PH_WAIT: begin
        if (is_hdr) phase_nxt = PH_LOW;
      end
      PH_LOW: begin
        low_nxt   = rx_byte;
        phase_nxt = PH_HIGH;
      end
      PH_HIGH: begin
        high_nxt  = rx_byte;
        phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        if (rx_byte == expect_sum) begin
          res.frame_done   = 1'b1;
          res.range_mm     = mm_val;
          res.in_range     = (mm_val >= cfg.min_mm) &&
                             (mm_val < cfg.max_mm);
          res.sample_total = good_r + 32'd1;
          phase_nxt        = PH_WAIT;
        end else begin
          res.checksum_error = 1'b1;
          res.error_total    = bad_r + 32'd1;
          // a bad checksum that is itself a header starts the next frame
          phase_nxt          = is_hdr ? PH_LOW : PH_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      low_r   <= '0;
      high_r  <= '0;
      good_r  <= '0;
      bad_r   <= '0;
      bytes_r <= '0;
      c5a_r   <= '0;
      chdr_r  <= '0;
      c55_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      good_r  <= res.sample_total;
      bad_r   <= res.error_total;
      bytes_r <= res.byte_total;
      c5a_r   <= res.count_5a_bytes;
      chdr_r  <= res.count_header_bytes;
      c55_r   <= res.count_55_bytes;
    end
  end

`ifndef SYNTH
  a_done_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.frame_done && res.checksum_error))
    else $error("frame_done and checksum_error both set");

  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> bytes_r == $past(bytes_r) + 32'd1)
    else $error("byte counter missed a beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(bytes_r) && $stable(phase_r) && $stable(good_r))
    else $error("parser state moved without a beat");

  a_done_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.frame_done) |=> phase_r == PH_WAIT && good_r == $past(good_r) + 32'd1)
    else $error("good frame did not return to header search");

  a_err_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    res.checksum_error |-> phase_r == PH_CHECK)
    else $error("checksum error outside checksum phase");
`endif

endmodule

>>> design/rangefinder_frame_parser.sv
// ----------------------------------------------------------------------------
// rangefinder_frame_parser: laser rangefinder serial frame parser
// One received byte per input beat; one result beat per byte.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_rx_byte) takes one link byte per beat.
// Output channel (out_valid/out_ready/out_*) returns one result per byte:
// frame_done with distance and in-range flag on a good checksum,
// checksum_error on a bad one, and the six wrapping 32-bit counters as they
// stand after that byte.
// A byte accepted into the input register moves on to the result register
// when the result register is free (empty or being taken), and its result is
// then offered. Throughput is one byte per cycle while out_ready stays high;
// the only path limiting it is the 32-bit counter increments between the two
// registers.
// Reset (rst_n low, synchronous) empties both registers, puts the parser in
// header search, clears the counters and loads the default header 0x5C and the
// 50..50000 mm window (50000 excluded). Config writes take effect at once
// and must be made while no byte is in flight; the block does not enforce it.
// When the receiver holds out_ready low, the result register holds, the
// input register fills, and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module rangefinder_frame_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_frame_done,
  output logic [15:0]                    out_distance_mm,
  output logic                           out_in_range,
  output logic                           out_checksum_error,
  output logic [31:0]                    out_sample_total,
  output logic [31:0]                    out_error_total,
  output logic [31:0]                    out_byte_total,
  output logic [31:0]                    out_count_5a_bytes,
  output logic [31:0]                    out_count_header_bytes,
  output logic [31:0]                    out_count_55_bytes,
  input  logic                           cfg_we,
  input  logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rfp_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res_r;
  logic    in_valid_r;
  logic    out_valid_r;
  logic    [7:0] in_byte_r;
  logic    advance;

  rfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // byte in the input stage moves on when the result register is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
    if (advance) out_res_r <= res;
  end

  assign out_valid              = out_valid_r;
  assign out_frame_done         = out_res_r.frame_done;
  assign out_distance_mm        = out_res_r.range_mm;
  assign out_in_range           = out_res_r.in_range;
  assign out_checksum_error     = out_res_r.checksum_error;
  assign out_sample_total       = out_res_r.sample_total;
  assign out_error_total        = out_res_r.error_total;
  assign out_byte_total         = out_res_r.byte_total;
  assign out_count_5a_bytes     = out_res_r.count_5a_bytes;
  assign out_count_header_bytes = out_res_r.count_header_bytes;
  assign out_count_55_bytes     = out_res_r.count_55_bytes;

endmodule

>>> bench/rangefinder_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// rangefinder_frame_parser_tb: self-checking bench for the frame parser
// Feeds link bytes (directed frames, then random frames, corrupt frames and
// noise) under several header and distance-window settings, predicts every
// result beat from a local model of the parser and compares it field by field.
// ----------------------------------------------------------------------------
module rangefinder_frame_parser_tb;
  import rfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // no register behind it
  localparam int QUIET_LIMIT = 3000;

  typedef enum logic [1:0] {PH_HUNT, PH_LOW, PH_HIGH, PH_SUM} parse_phase_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_frame_done;
  logic [15:0]           out_distance_mm;
  logic                  out_in_range;
  logic                  out_checksum_error;
  logic [31:0]           out_sample_total;
  logic [31:0]           out_error_total;
  logic [31:0]           out_byte_total;
  logic [31:0]           out_count_5a_bytes;
  logic [31:0]           out_count_header_bytes;
  logic [31:0]           out_count_55_bytes;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // model of the parser
  logic [7:0]   hdr_cfg = HEADER_RST;
  logic [15:0]  min_cfg = MIN_DIST_RST;
  logic [15:0]  max_cfg = MAX_DIST_RST;
  parse_phase_e phase = PH_HUNT;
  logic [7:0]   lo_q = '0;
  logic [7:0]   hi_q = '0;
  logic [31:0]  good_cnt = '0;
  logic [31:0]  bad_cnt = '0;
  logic [31:0]  byte_cnt = '0;
  logic [31:0]  cnt_5a = '0;
  logic [31:0]  cnt_hdr = '0;
  logic [31:0]  cnt_55 = '0;

  logic [7:0] pending_bytes[$];
  result_t    expected_results[$];

  int mismatches = 0;
  int send_gap_pct = 33;
  int recv_gap_pct = 33;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet = 0;
  int frames_seen = 0;
  int csum_errs_seen = 0;
  int settings_run = 1;

  rangefinder_frame_parser DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_frame_done        (out_frame_done),
    .out_distance_mm       (out_distance_mm),
    .out_in_range          (out_in_range),
    .out_checksum_error    (out_checksum_error),
    .out_sample_total      (out_sample_total),
    .out_error_total       (out_error_total),
    .out_byte_total        (out_byte_total),
    .out_count_5a_bytes    (out_count_5a_bytes),
    .out_count_header_bytes(out_count_header_bytes),
    .out_count_55_bytes    (out_count_55_bytes),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] frame_sum(logic [7:0] lo, logic [7:0] hi);
    logic [7:0] s;
    s = 8'(lo + hi);
    return ~s;
  endfunction

  // advance the parser model by one byte and return the result it gives
  function automatic result_t model_step(logic [7:0] b);
    result_t r;
    logic [15:0] mm;
    r = '0;
    byte_cnt++;
    if (b == BYTE_5A) cnt_5a++;
    else if (b == hdr_cfg) cnt_hdr++;
    else if (b == BYTE_55) cnt_55++;
    case (phase)
      PH_HUNT: begin
        if (b == hdr_cfg) phase = PH_LOW;
      end
      PH_LOW: begin
        lo_q = b;
        phase = PH_HIGH;
      end
      PH_HIGH: begin
        hi_q = b;
        phase = PH_SUM;
      end
      default: begin
        if (b == frame_sum(lo_q, hi_q)) begin
          mm = {hi_q, lo_q};
          r.frame_done = 1'b1;
          r.range_mm = mm;
          r.in_range = (mm >= min_cfg) && (mm < max_cfg);
          good_cnt++;
          phase = PH_HUNT;
        end else begin
          r.checksum_error = 1'b1;
          bad_cnt++;
          // a bad checksum that is itself a header opens the next frame
          phase = (b == hdr_cfg) ? PH_LOW : PH_HUNT;
        end
      end
    endcase
    r.sample_total = good_cnt;
    r.error_total = bad_cnt;
    r.byte_total = byte_cnt;
    r.count_5a_bytes = cnt_5a;
    r.count_header_bytes = cnt_hdr;
    r.count_55_bytes = cnt_55;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: input beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(model_step(in_rx_byte));
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result beats
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (out_frame_done) frames_seen++;
        if (out_checksum_error) csum_errs_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with no byte outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_frame_done", 32'(want.frame_done), 32'(out_frame_done));
          check_field("out_distance_mm", 32'(want.range_mm), 32'(out_distance_mm));
          check_field("out_in_range", 32'(want.in_range), 32'(out_in_range));
          check_field("out_checksum_error", 32'(want.checksum_error),
                      32'(out_checksum_error));
          check_field("out_sample_total", want.sample_total, out_sample_total);
          check_field("out_error_total", want.error_total, out_error_total);
          check_field("out_byte_total", want.byte_total, out_byte_total);
          check_field("out_count_5a_bytes", want.count_5a_bytes, out_count_5a_bytes);
          check_field("out_count_header_bytes", want.count_header_bytes,
                      out_count_header_bytes);
          check_field("out_count_55_bytes", want.count_55_bytes, out_count_55_bytes);
        end
      end
      if (hold_request) begin
        hold_left = 300;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FRAME_HEADER: hdr_cfg = val[7:0];
      REG_MIN_DIST:     min_cfg = val;
      REG_MAX_DIST:     max_cfg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_frame(input logic [15:0] mm);
    pending_bytes.push_back(hdr_cfg);
    pending_bytes.push_back(mm[7:0]);
    pending_bytes.push_back(mm[15:8]);
    pending_bytes.push_back(frame_sum(mm[7:0], mm[15:8]));
  endtask

  // mostly good frames, some corrupt or cut short, some line noise
  task automatic queue_traffic(input int n);
    int start, kind;
    logic [15:0] mm;
    logic [7:0] good;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n) begin
      kind = $urandom_range(99);
      case ($urandom_range(7))
        0: mm = min_cfg - 16'd1;
        1: mm = min_cfg;
        2: mm = max_cfg - 16'd1;
        3: mm = max_cfg;
        default: mm = 16'($urandom);
      endcase
      good = frame_sum(mm[7:0], mm[15:8]);
      if (kind < 60) begin
        push_frame(mm);
      end else if (kind < 70) begin
        pending_bytes.push_back(hdr_cfg);
        pending_bytes.push_back(mm[7:0]);
        pending_bytes.push_back(mm[15:8]);
        pending_bytes.push_back(good ^ 8'($urandom_range(1, 255)));
      end else if (kind < 78) begin
        // header in the checksum slot, then the rest of a frame
        pending_bytes.push_back(hdr_cfg);
        pending_bytes.push_back(mm[7:0]);
        pending_bytes.push_back(mm[15:8]);
        pending_bytes.push_back(hdr_cfg);
        push_frame(16'($urandom));
        void'(pending_bytes.pop_back());
        void'(pending_bytes.pop_back());
        void'(pending_bytes.pop_back());
        void'(pending_bytes.pop_back());
        mm = 16'($urandom);
        pending_bytes.push_back(mm[7:0]);
        pending_bytes.push_back(mm[15:8]);
        pending_bytes.push_back(frame_sum(mm[7:0], mm[15:8]));
      end else if (kind < 88) begin
        pending_bytes.push_back(hdr_cfg);
        repeat ($urandom_range(1, 2)) pending_bytes.push_back(8'($urandom));
      end else begin
        case ($urandom_range(3))
          0: pending_bytes.push_back(BYTE_5A);
          1: pending_bytes.push_back(BYTE_55);
          2: pending_bytes.push_back(hdr_cfg);
          default: pending_bytes.push_back(8'($urandom));
        endcase
      end
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_setting(input logic [7:0] hdr, input logic [15:0] lo_lim,
                             input logic [15:0] hi_lim, input int n,
                             input int send_pct, input int recv_pct, input bit hold);
    write_reg(REG_FRAME_HEADER, {8'($urandom), hdr});
    write_reg(REG_MIN_DIST, lo_lim);
    write_reg(REG_MAX_DIST, hi_lim);
    settings_run++;
    @(negedge clk);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    queue_traffic(n);
    if (hold) hold_request = 1'b1;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset settings: window edges, distance extremes, header as bad checksum
    push_frame(16'd0);
    push_frame(16'hFFFF);
    push_frame(16'd50);
    push_frame(16'd50000);
    pending_bytes.push_back(HEADER_RST);
    pending_bytes.push_back(8'h34);
    pending_bytes.push_back(8'h12);
    pending_bytes.push_back(HEADER_RST);
    pending_bytes.push_back(8'h10);
    pending_bytes.push_back(8'h27);
    pending_bytes.push_back(frame_sum(8'h10, 8'h27));
    pending_bytes.push_back(BYTE_5A);
    pending_bytes.push_back(BYTE_55);
    queue_traffic(300);
    drain();

    run_setting(BYTE_5A, 16'd0, 16'hFFFF, 200, 33, 33, 1'b0);
    run_setting(BYTE_55, 16'd1000, 16'd1000, 200, 33, 33, 1'b0);
    run_setting(8'hFF, 16'hFFFF, 16'd0, 150, 33, 33, 1'b0);
    run_setting(8'h00, 16'd0, 16'd0, 150, 33, 33, 1'b0);
    write_reg(REG_UNUSED, 16'($urandom));
    run_setting(8'hA3, 16'd100, 16'd40000, 300, 0, 0, 1'b0);
    run_setting(HEADER_RST, 16'd49, 16'd60000, 300, 0, 33, 1'b1);

    $display("%0d bytes under %0d register settings: %0d good frames, %0d checksum errors",
             byte_cnt, settings_run, frames_seen, csum_errs_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/rfp_pkg.sv
design/rfp_cfg_regs.sv
design/rfp_parser.sv
design/rangefinder_frame_parser.sv
bench/rangefinder_frame_parser_tb.sv
